// File: rtl/blu_pkg.sv
`timescale 1ns / 1ps

package blu_pkg;

	// Fixed widths of the stream fields and of the internal datapath.
	localparam int IO_W     = 32;
	localparam int FRAC_W   = 16;
	localparam int ROW_W    = 6;
	localparam int SUM_W    = 50;
	localparam int QUOT_W   = 49;
	localparam int DIV_BITS = 48;

	// Result status codes.
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_ZERO_PIVOT = 2'd1;
	localparam logic [1:0] STAT_TOO_MANY   = 2'd2;
	localparam logic [1:0] STAT_TOO_FEW    = 2'd3;

	// Datapath operations.
	localparam logic [4:0] OP_NOP        = 5'd0;
	localparam logic [4:0] OP_LOAD       = 5'd1;
	localparam logic [4:0] OP_MUL_A_PM2  = 5'd2;
	localparam logic [4:0] OP_ALPHA      = 5'd3;
	localparam logic [4:0] OP_MUL_AL_PM1 = 5'd4;
	localparam logic [4:0] OP_BETA       = 5'd5;
	localparam logic [4:0] OP_MUL_PF1_AL = 5'd6;
	localparam logic [4:0] OP_ACC        = 5'd7;
	localparam logic [4:0] OP_MUL_PF2_A  = 5'd8;
	localparam logic [4:0] OP_NUM        = 5'd9;
	localparam logic [4:0] OP_DIV        = 5'd10;
	localparam logic [4:0] OP_COMMIT     = 5'd11;
	localparam logic [4:0] OP_OUT_ERR    = 5'd12;
	localparam logic [4:0] OP_BS_INIT    = 5'd13;
	localparam logic [4:0] OP_BS_MUL     = 5'd14;
	localparam logic [4:0] OP_BS_SUB     = 5'd15;
	localparam logic [4:0] OP_OUT_SOL    = 5'd16;

	typedef struct packed {
		logic [4:0]       op;
		logic [ROW_W-1:0] addr;
		logic             zero_a;
		logic             zero_b;
		logic             last;
		logic [1:0]       code;
	} blu_cmd_t;

	typedef struct packed {
		logic beta_zero;
		logic div_done;
		logic out_free;
	} blu_stat_t;

endpackage

// File: rtl/banded_lu_solver_core.sv
`timescale 1ns / 1ps

// Banded LU solver for a matrix with two subdiagonals, the main diagonal and one
// superdiagonal, all in signed Q16.16. Feed one row per input word; each row is
// factored and forward-substituted on arrival: a
// short chain of multiply and saturating-add steps through one shared 32x32
// multiplier, then two bit-serial dividers running side by side.
// The row marked with tlast starts back substitution, a read, multiply and
// subtract step per row, and the solution then leaves in ascending row order,
// with a read step before each word. A zero pivot, more than MAX_ROWS rows or fewer than two
// rows yields one error word instead (status in tuser, tlast set). Input is taken
// only while no row is in progress; the output register lets the next system
// start while the last word of the previous one still waits to be taken.
module banded_lu_solver_core #(
	parameter int MAX_ROWS   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// sub2_coef[31:0], sub1_coef[63:32], diag_coef[95:64], super_coef[127:96],
	// rhs_value[159:128]
	input  logic [159:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// solution_value[31:0], row_index[37:32], zero padding[39:38]
	output logic [39:0]  m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	blu_pkg::blu_cmd_t  cmd;
	blu_pkg::blu_stat_t stat;
	logic signed [31:0] sol;
	logic [5:0]         row;

	// The controller walks each row through the shared arithmetic and then
	// runs back substitution and emission as address sequences.
	blu_ctrl #(
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// The datapath holds the multiplier, dividers, stores and output register.
	blu_dpath #(
		.MAX_ROWS   (MAX_ROWS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_a       (s_axis_tdata[31:0]),
		.in_b       (s_axis_tdata[63:32]),
		.in_c       (s_axis_tdata[95:64]),
		.in_d       (s_axis_tdata[127:96]),
		.in_f       (s_axis_tdata[159:128]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sol    (sol),
		.out_row    (row),
		.out_last   (m_axis_tlast),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {2'b00, row, sol};

endmodule

// File: rtl/blu_div.sv
`timescale 1ns / 1ps

// Signed Q16.16 divider: (n * 2^16) / d truncated toward zero, one quotient bit per cycle.
module blu_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [blu_pkg::IO_W-1:0]     dividend,
	input  logic signed [blu_pkg::IO_W-1:0]     divisor,
	output logic                                done,
	output logic signed [blu_pkg::QUOT_W-1:0]   quot
);

	logic                             busy_q;
	logic                             done_q;
	logic [5:0]                       cnt_q;
	logic [blu_pkg::IO_W-1:0]         rem_q;
	logic [blu_pkg::DIV_BITS-1:0]     quo_q;
	logic [blu_pkg::IO_W-1:0]         dvs_q;
	logic                             neg_q;
	logic [blu_pkg::IO_W:0]           trial;
	logic                             fits;
	logic [blu_pkg::IO_W-1:0]         abs_n;
	logic [blu_pkg::IO_W-1:0]         abs_d;

	assign abs_n = dividend[blu_pkg::IO_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_d = divisor[blu_pkg::IO_W-1] ? (~divisor + 1'b1) : divisor;
	assign trial = {rem_q, quo_q[blu_pkg::DIV_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 6'(blu_pkg::DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= {abs_n, {blu_pkg::FRAC_W{1'b0}}};
			dvs_q <= abs_d;
			neg_q <= dividend[blu_pkg::IO_W-1] ^ divisor[blu_pkg::IO_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? blu_pkg::IO_W'(trial - {1'b0, dvs_q}) : trial[blu_pkg::IO_W-1:0];
			quo_q <= {quo_q[blu_pkg::DIV_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// File: rtl/blu_dpath.sv
`timescale 1ns / 1ps

module blu_dpath #(
	parameter int MAX_ROWS   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  blu_pkg::blu_cmd_t                 cmd,
	output blu_pkg::blu_stat_t                stat,
	input  logic signed [blu_pkg::IO_W-1:0]   in_a,
	input  logic signed [blu_pkg::IO_W-1:0]   in_b,
	input  logic signed [blu_pkg::IO_W-1:0]   in_c,
	input  logic signed [blu_pkg::IO_W-1:0]   in_d,
	input  logic signed [blu_pkg::IO_W-1:0]   in_f,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [blu_pkg::IO_W-1:0]   out_sol,
	output logic [blu_pkg::ROW_W-1:0]         out_row,
	output logic                              out_last,
	output logic [1:0]                        out_status
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int SB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam logic signed [blu_pkg::SUM_W-1:0] SAT_HI =
		(50'sd1 <<< (SB - 1)) - 50'sd1;
	localparam logic signed [blu_pkg::SUM_W-1:0] SAT_LO = -SAT_HI - 50'sd1;

	function automatic logic signed [31:0] sat(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI)
			r = SAT_HI[31:0];
		else if (v < SAT_LO)
			r = SAT_LO[31:0];
		else
			r = v[31:0];
		return r;
	endfunction

	logic signed [31:0] a_q, b_q, c_q, d_q, f_q;
	logic signed [31:0] alpha_q, beta_q, num_q, u_q;
	logic signed [49:0] acc_q;
	logic signed [31:0] pm1_q, pm2_q, pf1_q, pf2_q;
	logic signed [63:0] prod_s1;
	logic signed [47:0] fl;
	logic signed [31:0] ma, mb;
	logic signed [31:0] fs_rd_q, ms_rd_q, u_rd_q;
	logic signed [31:0] fs_mem [MAX_ROWS];
	logic signed [31:0] ms_mem [MAX_ROWS];
	logic signed [31:0] u_mem  [MAX_ROWS];
	logic [AW-1:0]      addr;
	logic               div_start;
	logic               div_done;
	logic               div_done_z;
	logic signed [48:0] q_phi, q_z;
	logic signed [31:0] phi, z, bs_u;
	logic               clr;
	logic               out_valid_q;
	logic               out_last_q;
	logic signed [31:0] out_sol_q;
	logic [5:0]         out_row_q;
	logic [1:0]         out_status_q;

	assign addr      = cmd.addr[AW-1:0];
	assign fl        = prod_s1[63:16];
	assign div_start = (cmd.op == blu_pkg::OP_DIV);
	assign phi       = cmd.last ? 32'sd0 : sat(50'(q_phi));
	assign z         = sat(50'(q_z));
	assign bs_u      = sat(50'(fs_rd_q) - 50'(fl));
	assign clr       = (cmd.op == blu_pkg::OP_OUT_ERR) ||
	                   ((cmd.op == blu_pkg::OP_OUT_SOL) && cmd.last);

	blu_div u_div_phi (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (d_q),
		.divisor  (beta_q),
		.done     (div_done),
		.quot     (q_phi)
	);

	blu_div u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (beta_q),
		.done     (div_done_z),
		.quot     (q_z)
	);

	always_comb begin
		ma = a_q;
		mb = pm2_q;
		case (cmd.op)
			blu_pkg::OP_MUL_AL_PM1: begin ma = alpha_q; mb = pm1_q; end
			blu_pkg::OP_MUL_PF1_AL: begin ma = pf1_q;   mb = alpha_q; end
			blu_pkg::OP_MUL_PF2_A:  begin ma = pf2_q;   mb = a_q; end
			blu_pkg::OP_BS_MUL:     begin ma = ms_rd_q; mb = u_q; end
			default:                begin ma = a_q;     mb = pm2_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		fs_rd_q <= fs_mem[addr];
		ms_rd_q <= ms_mem[addr];
		u_rd_q  <= u_mem[addr];
		case (cmd.op)
			blu_pkg::OP_LOAD: begin
				a_q <= cmd.zero_a ? 32'sd0 : in_a;
				b_q <= cmd.zero_b ? 32'sd0 : in_b;
				c_q <= in_c;
				d_q <= in_d;
				f_q <= in_f;
			end
			blu_pkg::OP_ALPHA: alpha_q <= sat(50'(b_q) - 50'(fl));
			blu_pkg::OP_BETA:  beta_q  <= sat(50'(c_q) - 50'(fl));
			blu_pkg::OP_ACC:   acc_q   <= 50'(f_q) - 50'(fl);
			blu_pkg::OP_NUM:   num_q   <= sat(acc_q - 50'(fl));
			blu_pkg::OP_COMMIT: begin
				fs_mem[addr] <= z;
				ms_mem[addr] <= phi;
			end
			blu_pkg::OP_BS_INIT: begin
				u_q         <= fs_rd_q;
				u_mem[addr] <= fs_rd_q;
			end
			blu_pkg::OP_BS_SUB: begin
				u_q         <= bs_u;
				u_mem[addr] <= bs_u;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm1_q <= '0;
			pm2_q <= '0;
			pf1_q <= '0;
			pf2_q <= '0;
		end else if (clr) begin
			pm1_q <= '0;
			pm2_q <= '0;
			pf1_q <= '0;
			pf2_q <= '0;
		end else if (cmd.op == blu_pkg::OP_COMMIT) begin
			pm2_q <= pm1_q;
			pm1_q <= phi;
			pf2_q <= pf1_q;
			pf1_q <= z;
		end
	end

	// Output register; it frees when the downstream side takes the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == blu_pkg::OP_OUT_SOL || cmd.op == blu_pkg::OP_OUT_ERR)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == blu_pkg::OP_OUT_SOL) begin
			out_sol_q    <= u_rd_q;
			out_row_q    <= cmd.addr;
			out_last_q   <= cmd.last;
			out_status_q <= blu_pkg::STAT_OK;
		end else if (cmd.op == blu_pkg::OP_OUT_ERR) begin
			out_sol_q    <= '0;
			out_row_q    <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.code;
		end
	end

	// Both dividers start together and finish in the same cycle.
	assign stat.beta_zero = (beta_q == 32'sd0);
	assign stat.div_done  = div_done && div_done_z;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_sol        = out_sol_q;
	assign out_row        = out_row_q;
	assign out_last       = out_last_q;
	assign out_status     = out_status_q;

endmodule

// File: rtl/blu_ctrl.sv
`timescale 1ns / 1ps

module blu_ctrl #(
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output blu_pkg::blu_cmd_t  cmd,
	input  blu_pkg::blu_stat_t stat
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_M1      = 5'd1;
	localparam logic [4:0] S_ALPHA   = 5'd2;
	localparam logic [4:0] S_M2      = 5'd3;
	localparam logic [4:0] S_BETA    = 5'd4;
	localparam logic [4:0] S_CHK     = 5'd5;
	localparam logic [4:0] S_M3      = 5'd6;
	localparam logic [4:0] S_ACC     = 5'd7;
	localparam logic [4:0] S_M4      = 5'd8;
	localparam logic [4:0] S_NUM     = 5'd9;
	localparam logic [4:0] S_DIV     = 5'd10;
	localparam logic [4:0] S_WDIV    = 5'd11;
	localparam logic [4:0] S_DECIDE  = 5'd12;
	localparam logic [4:0] S_ERR     = 5'd13;
	localparam logic [4:0] S_BS_RD0  = 5'd14;
	localparam logic [4:0] S_BS_INIT = 5'd15;
	localparam logic [4:0] S_BS_RD   = 5'd16;
	localparam logic [4:0] S_BS_MUL  = 5'd17;
	localparam logic [4:0] S_BS_SUB  = 5'd18;
	localparam logic [4:0] S_EM_RD   = 5'd19;
	localparam logic [4:0] S_EM_OUT  = 5'd20;

	logic [4:0]    state_q;
	logic [CW-1:0] row_cnt_q;
	logic [1:0]    err_q;
	logic [1:0]    code_q;
	logic          last_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] bsi_q;
	logic [AW-1:0] emi_q;
	logic [AW-1:0] bsi_m1;
	logic [CW-1:0] tm1;
	logic          accept;
	logic          em_last;
	logic [4:0]    after_row;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign tm1       = row_cnt_q - 1'b1;
	assign bsi_m1    = bsi_q - 1'b1;
	assign em_last   = (CW'(emi_q) == tm1);
	assign after_row = last_q ? S_DECIDE : S_IDLE;

	always_comb begin
		cmd        = '0;
		cmd.op     = blu_pkg::OP_NOP;
		cmd.zero_a = (row_cnt_q < CW'(2));
		cmd.zero_b = (row_cnt_q == '0);
		case (state_q)
			S_IDLE:  if (accept) cmd.op = blu_pkg::OP_LOAD;
			S_M1:    cmd.op = blu_pkg::OP_MUL_A_PM2;
			S_ALPHA: cmd.op = blu_pkg::OP_ALPHA;
			S_M2:    cmd.op = blu_pkg::OP_MUL_AL_PM1;
			S_BETA:  cmd.op = blu_pkg::OP_BETA;
			S_M3:    cmd.op = blu_pkg::OP_MUL_PF1_AL;
			S_ACC:   cmd.op = blu_pkg::OP_ACC;
			S_M4:    cmd.op = blu_pkg::OP_MUL_PF2_A;
			S_NUM:   cmd.op = blu_pkg::OP_NUM;
			S_DIV:   cmd.op = blu_pkg::OP_DIV;
			S_WDIV: begin
				cmd.addr = blu_pkg::ROW_W'(idx_q);
				cmd.last = last_q;
				if (stat.div_done) cmd.op = blu_pkg::OP_COMMIT;
			end
			S_ERR: begin
				cmd.code = code_q;
				if (stat.out_free) cmd.op = blu_pkg::OP_OUT_ERR;
			end
			S_BS_RD0: cmd.addr = blu_pkg::ROW_W'(bsi_q);
			S_BS_INIT: begin
				cmd.addr = blu_pkg::ROW_W'(bsi_q);
				cmd.op   = blu_pkg::OP_BS_INIT;
			end
			S_BS_RD: cmd.addr = blu_pkg::ROW_W'(bsi_m1);
			S_BS_MUL: begin
				cmd.addr = blu_pkg::ROW_W'(bsi_m1);
				cmd.op   = blu_pkg::OP_BS_MUL;
			end
			S_BS_SUB: begin
				cmd.addr = blu_pkg::ROW_W'(bsi_m1);
				cmd.op   = blu_pkg::OP_BS_SUB;
			end
			S_EM_RD: cmd.addr = blu_pkg::ROW_W'(emi_q);
			S_EM_OUT: begin
				cmd.addr = blu_pkg::ROW_W'(emi_q);
				cmd.last = em_last;
				if (stat.out_free) cmd.op = blu_pkg::OP_OUT_SOL;
			end
			default: cmd.op = blu_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_cnt_q <= '0;
			err_q     <= blu_pkg::STAT_OK;
			code_q    <= blu_pkg::STAT_OK;
			last_q    <= 1'b0;
			idx_q     <= '0;
			bsi_q     <= '0;
			emi_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= in_last;
						idx_q  <= row_cnt_q[AW-1:0];
						if (row_cnt_q >= CW'(MAX_ROWS)) begin
							if (err_q == blu_pkg::STAT_OK) err_q <= blu_pkg::STAT_TOO_MANY;
							state_q <= in_last ? S_DECIDE : S_IDLE;
						end else begin
							row_cnt_q <= row_cnt_q + 1'b1;
							if (err_q != blu_pkg::STAT_OK)
								state_q <= in_last ? S_DECIDE : S_IDLE;
							else
								state_q <= S_M1;
						end
					end
				end
				S_M1:    state_q <= S_ALPHA;
				S_ALPHA: state_q <= S_M2;
				S_M2:    state_q <= S_BETA;
				S_BETA:  state_q <= S_CHK;
				S_CHK: begin
					if (stat.beta_zero) begin
						err_q   <= blu_pkg::STAT_ZERO_PIVOT;
						state_q <= after_row;
					end else begin
						state_q <= S_M3;
					end
				end
				S_M3:  state_q <= S_ACC;
				S_ACC: state_q <= S_M4;
				S_M4:  state_q <= S_NUM;
				S_NUM: state_q <= S_DIV;
				S_DIV: state_q <= S_WDIV;
				S_WDIV: if (stat.div_done) state_q <= after_row;
				S_DECIDE: begin
					if (row_cnt_q < CW'(2)) begin
						code_q  <= blu_pkg::STAT_TOO_FEW;
						state_q <= S_ERR;
					end else if (err_q != blu_pkg::STAT_OK) begin
						code_q  <= err_q;
						state_q <= S_ERR;
					end else begin
						bsi_q   <= tm1[AW-1:0];
						state_q <= S_BS_RD0;
					end
				end
				S_ERR: begin
					if (stat.out_free) begin
						row_cnt_q <= '0;
						err_q     <= blu_pkg::STAT_OK;
						state_q   <= S_IDLE;
					end
				end
				S_BS_RD0:  state_q <= S_BS_INIT;
				S_BS_INIT: state_q <= S_BS_RD;
				S_BS_RD:   state_q <= S_BS_MUL;
				S_BS_MUL:  state_q <= S_BS_SUB;
				S_BS_SUB: begin
					bsi_q <= bsi_m1;
					if (bsi_m1 == '0) begin
						emi_q   <= '0;
						state_q <= S_EM_RD;
					end else begin
						state_q <= S_BS_RD;
					end
				end
				S_EM_RD: state_q <= S_EM_OUT;
				S_EM_OUT: begin
					if (stat.out_free) begin
						if (em_last) begin
							row_cnt_q <= '0;
							err_q     <= blu_pkg::STAT_OK;
							state_q   <= S_IDLE;
						end else begin
							emi_q   <= emi_q + 1'b1;
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == blu_pkg::OP_OUT_SOL || cmd.op == blu_pkg::OP_OUT_ERR) |-> stat.out_free)
		else $error("result loaded into a full output register");

	a_row_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= CW'(MAX_ROWS))
		else $error("row count beyond the row limit");

	a_first_err_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != blu_pkg::STAT_OK && state_q != S_ERR) |=> (err_q == $past(err_q)))
		else $error("held error code replaced");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == blu_pkg::OP_OUT_SOL && cmd.last) |=> (row_cnt_q == '0 && state_q == S_IDLE))
		else $error("system state not cleared after final result");
`endif

endmodule
